/* src/qsu_pkg.sv */
// ----------------------------------------------------------------------------
// qsu_pkg: shared types and helpers for the quoted string unescaper
// Result batch layout, UTF-8 encoding and hex digit decoding.
// ----------------------------------------------------------------------------
`default_nettype none

package qsu_pkg;

    localparam int NUM_SLOTS = 6;
    localparam int OUT_LEN_W = 16;

    // results produced by one input item, oldest in slot 0
    typedef struct packed {
        logic [NUM_SLOTS-1:0][7:0] bytes;
        logic [2:0]                count;
        logic                      is_end;
        logic                      error;
        logic [OUT_LEN_W-1:0]      length;
    } qsu_batch_t;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
    } qsu_utf8_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } qsu_hex_t;

    function automatic qsu_utf8_t utf8_enc(input logic [20:0] v);
        qsu_utf8_t r;
        r = '0;
        if (v < 21'h80) begin
            r.bytes[0] = v[7:0];
            r.count    = 3'd1;
        end
        else if (v < 21'h800) begin
            r.bytes[0] = {3'b110, v[10:6]};
            r.bytes[1] = {2'b10, v[5:0]};
            r.count    = 3'd2;
        end
        else if (v < 21'h10000) begin
            r.bytes[0] = {4'b1110, v[15:12]};
            r.bytes[1] = {2'b10, v[11:6]};
            r.bytes[2] = {2'b10, v[5:0]};
            r.count    = 3'd3;
        end
        else begin
            r.bytes[0] = {5'b11110, v[20:18]};
            r.bytes[1] = {2'b10, v[17:12]};
            r.bytes[2] = {2'b10, v[11:6]};
            r.bytes[3] = {2'b10, v[5:0]};
            r.count    = 3'd4;
        end
        return r;
    endfunction

    function automatic qsu_hex_t hex_dec(input logic [7:0] c);
        qsu_hex_t r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.ok    = 1'b1;
            r.value = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            r.ok    = 1'b1;
            r.value = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            r.ok    = 1'b1;
            r.value = 4'(c - 8'h37);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/qsu_in_stage.sv */
// ----------------------------------------------------------------------------
// qsu_in_stage: input register
// Holds one accepted item until the decoder can hand its results on.
// ----------------------------------------------------------------------------
`default_nettype none

module qsu_in_stage
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    input  wire logic       space,
    output logic            fire,
    output logic [7:0]      cur_byte,
    output logic            cur_last
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;

    assign fire     = valid_reg && space;
    assign in_ready = !valid_reg || fire;
    assign cur_byte = byte_reg;
    assign cur_last = last_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (fire)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
            last_reg <= in_last;
        end
    end

endmodule

`default_nettype wire

/* src/qsu_decoder.sv */
// ----------------------------------------------------------------------------
// qsu_decoder: escape decoder and token state
// Decodes one item into a batch of results and advances the parse state.
// ----------------------------------------------------------------------------
`default_nettype none

module qsu_decoder
    import qsu_pkg::*;
#(
    parameter int LEN_BITS = 16
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       fire,
    input  wire logic [7:0] cur_byte,
    input  wire logic       cur_last,
    output qsu_batch_t      batch
);

    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_BODY     = 4'd1;
    localparam logic [3:0] PH_ESC      = 4'd2;
    localparam logic [3:0] PH_HEXX     = 4'd3;
    localparam logic [3:0] PH_HEXU     = 4'd4;
    localparam logic [3:0] PH_HELD     = 4'd5;
    localparam logic [3:0] PH_HELD_ESC = 4'd6;
    localparam logic [3:0] PH_HELD_U   = 4'd7;
    localparam logic [3:0] PH_HELD_BAD = 4'd8;
    localparam logic [3:0] PH_FAILED   = 4'd9;

    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BQUOTE = 8'h60;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [1:0] ESC_LIT = 2'd0;
    localparam logic [1:0] ESC_X   = 2'd1;
    localparam logic [1:0] ESC_U   = 2'd2;
    localparam logic [1:0] ESC_BAD = 2'd3;

    localparam int WIDE_W = (LEN_BITS > OUT_LEN_W) ? LEN_BITS : OUT_LEN_W;
    localparam logic [LEN_BITS:0] COUNT_MAX = {1'b0, {LEN_BITS{1'b1}}};

    logic [7:0]          quote_reg,     quote_next;
    logic [3:0]          phase_reg,     phase_next;
    logic [15:0]         acc_reg,       acc_next;
    logic [2:0]          digits_reg,    digits_next;
    logic [9:0]          held_reg,      held_next;
    logic                held_flag_reg, held_flag_next;
    logic                failed_reg,    failed_next;
    logic [LEN_BITS-1:0] count_reg,     count_next;

    logic [1:0]  esc_kind;
    logic [7:0]  esc_byte;
    qsu_hex_t    hv;
    logic [15:0] acc_shift;
    logic [2:0]  digits_inc;
    qsu_utf8_t   enc_held;
    qsu_utf8_t   enc_b;
    logic [20:0] b_cp;
    logic [20:0] merged_cp;
    logic        is_quote;

    assign hv         = hex_dec(cur_byte);
    assign acc_shift  = {acc_reg[11:0], hv.value};
    assign digits_inc = digits_reg + 3'd1;
    assign enc_held   = utf8_enc({5'd0, 6'b110110, held_reg});
    assign merged_cp  = 21'h10000 + {1'b0, held_reg, acc_shift[9:0]};
    assign b_cp       = (phase_reg == PH_HELD_U && acc_shift >= 16'hdc00 && acc_shift < 16'he000)
                        ? merged_cp : {5'd0, acc_shift};
    assign enc_b      = utf8_enc(b_cp);
    assign is_quote   = cur_byte == CH_DQUOTE || cur_byte == CH_SQUOTE
                        || cur_byte == CH_BQUOTE;

    always_comb
    begin
        esc_kind = ESC_LIT;
        esc_byte = cur_byte;
        case (cur_byte)
            CH_BSLASH, CH_DQUOTE, CH_SQUOTE, CH_BQUOTE, CH_SLASH: esc_byte = cur_byte;
            CH_ZERO: esc_byte = 8'h00;
            CH_B:    esc_byte = 8'h08;
            CH_T:    esc_byte = 8'h09;
            CH_N:    esc_byte = 8'h0a;
            CH_F:    esc_byte = 8'h0c;
            CH_R:    esc_byte = 8'h0d;
            CH_E:    esc_byte = 8'h1b;
            CH_X:    esc_kind = ESC_X;
            CH_U:    esc_kind = ESC_U;
            default: esc_kind = ESC_BAD;
        endcase
    end

    always_comb
    begin
        logic                a_en;
        logic                b_raw;
        logic                b_enc;
        logic [7:0]          raw_byte;
        logic                end_en;
        logic                err;
        logic                do_esc;
        logic [3:0][7:0]     b_bytes;
        logic [2:0]          na;
        logic [2:0]          nb;
        logic [2:0]          j;
        logic [LEN_BITS:0]   sum;
        logic [LEN_BITS-1:0] sat;
        logic [WIDE_W-1:0]   sat_w;

        quote_next     = quote_reg;
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        digits_next    = digits_reg;
        held_next      = held_reg;
        held_flag_next = held_flag_reg;
        failed_next    = failed_reg;
        a_en           = 1'b0;
        b_raw          = 1'b0;
        b_enc          = 1'b0;
        raw_byte       = cur_byte;
        end_en         = 1'b0;
        err            = failed_reg;
        do_esc         = 1'b0;

        if (cur_last)
        begin
            end_en = 1'b1;
            if (!failed_reg)
            begin
                if (phase_reg == PH_IDLE || cur_byte != quote_reg)
                begin
                    err = 1'b1;
                end
                else
                begin
                    a_en = held_flag_reg;
                    if (phase_reg != PH_BODY && phase_reg != PH_HELD)
                    begin
                        err = 1'b1;
                    end
                end
            end
        end
        else if (!failed_reg)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (is_quote)
                    begin
                        quote_next = cur_byte;
                        phase_next = PH_BODY;
                    end
                    else
                    begin
                        failed_next = 1'b1;
                        phase_next  = PH_FAILED;
                    end
                end
                PH_BODY:
                begin
                    if (cur_byte == CH_BSLASH)
                    begin
                        phase_next = PH_ESC;
                    end
                    else
                    begin
                        b_raw = 1'b1;
                    end
                end
                PH_ESC:
                begin
                    do_esc = 1'b1;
                end
                PH_HEXX, PH_HEXU:
                begin
                    if (!hv.ok)
                    begin
                        failed_next = 1'b1;
                        phase_next  = PH_FAILED;
                    end
                    else
                    begin
                        acc_next    = acc_shift;
                        digits_next = digits_inc;
                        if (phase_reg == PH_HEXX && digits_inc >= 3'd2)
                        begin
                            b_raw      = 1'b1;
                            raw_byte   = acc_shift[7:0];
                            phase_next = PH_BODY;
                        end
                        else if (phase_reg == PH_HEXU && digits_inc >= 3'd4)
                        begin
                            if (acc_shift >= 16'hd800 && acc_shift < 16'hdc00)
                            begin
                                held_next      = acc_shift[9:0];
                                held_flag_next = 1'b1;
                                phase_next     = PH_HELD;
                            end
                            else
                            begin
                                b_enc      = 1'b1;
                                phase_next = PH_BODY;
                            end
                        end
                    end
                end
                PH_HELD:
                begin
                    if (cur_byte == CH_BSLASH)
                    begin
                        phase_next = PH_HELD_ESC;
                    end
                    else
                    begin
                        a_en           = 1'b1;
                        held_next      = '0;
                        held_flag_next = 1'b0;
                        b_raw          = 1'b1;
                        phase_next     = PH_BODY;
                    end
                end
                PH_HELD_ESC:
                begin
                    if (cur_byte == CH_U)
                    begin
                        acc_next    = '0;
                        digits_next = '0;
                        phase_next  = PH_HELD_U;
                    end
                    else
                    begin
                        a_en           = 1'b1;
                        held_next      = '0;
                        held_flag_next = 1'b0;
                        do_esc         = 1'b1;
                    end
                end
                PH_HELD_U:
                begin
                    if (!hv.ok)
                    begin
                        if (digits_reg[1:0] == 2'd3)
                        begin
                            failed_next    = 1'b1;
                            held_flag_next = 1'b0;
                            phase_next     = PH_FAILED;
                        end
                        else
                        begin
                            digits_next = 3'd3 - {1'b0, digits_reg[1:0]};
                            phase_next  = PH_HELD_BAD;
                        end
                    end
                    else
                    begin
                        acc_next    = acc_shift;
                        digits_next = digits_inc;
                        if (digits_inc >= 3'd4)
                        begin
                            held_next      = '0;
                            held_flag_next = 1'b0;
                            phase_next     = PH_BODY;
                            if (acc_shift >= 16'hdc00 && acc_shift < 16'he000)
                            begin
                                b_enc = 1'b1;
                            end
                            else
                            begin
                                a_en = 1'b1;
                                if (acc_shift >= 16'hd800 && acc_shift < 16'hdc00)
                                begin
                                    held_next      = acc_shift[9:0];
                                    held_flag_next = 1'b1;
                                    phase_next     = PH_HELD;
                                end
                                else
                                begin
                                    b_enc = 1'b1;
                                end
                            end
                        end
                    end
                end
                PH_HELD_BAD:
                begin
                    if (digits_reg <= 3'd1)
                    begin
                        digits_next    = '0;
                        failed_next    = 1'b1;
                        held_flag_next = 1'b0;
                        phase_next     = PH_FAILED;
                    end
                    else
                    begin
                        digits_next = digits_reg - 3'd1;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase

            if (do_esc)
            begin
                case (esc_kind)
                    ESC_LIT:
                    begin
                        b_raw      = 1'b1;
                        raw_byte   = esc_byte;
                        phase_next = PH_BODY;
                    end
                    ESC_X:
                    begin
                        acc_next    = '0;
                        digits_next = '0;
                        phase_next  = PH_HEXX;
                    end
                    ESC_U:
                    begin
                        acc_next    = '0;
                        digits_next = '0;
                        phase_next  = PH_HEXU;
                    end
                    default:
                    begin
                        failed_next    = 1'b1;
                        held_flag_next = 1'b0;
                        phase_next     = PH_FAILED;
                    end
                endcase
            end
        end

        // assemble the batch: held surrogate first, then the new bytes, then end
        na      = a_en ? 3'd3 : 3'd0;
        b_bytes = '0;
        nb      = 3'd0;
        if (b_raw)
        begin
            b_bytes[0] = raw_byte;
            nb         = 3'd1;
        end
        else if (b_enc)
        begin
            b_bytes = enc_b.bytes;
            nb      = enc_b.count;
        end

        batch = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            j = 3'(i) - na;
            if (a_en && 3'(i) < 3'd3)
            begin
                batch.bytes[i] = enc_held.bytes[i[1:0]];
            end
            else if (j < nb)
            begin
                batch.bytes[i] = b_bytes[j[1:0]];
            end
        end
        batch.count  = na + nb + {2'd0, end_en};
        batch.is_end = end_en;
        batch.error  = err;

        sum = {1'b0, count_reg} + (LEN_BITS+1)'(na + nb);
        sat = (sum > COUNT_MAX) ? COUNT_MAX[LEN_BITS-1:0] : sum[LEN_BITS-1:0];
        sat_w = WIDE_W'(sat);
        batch.length = (sat_w > WIDE_W'(16'hffff)) ? 16'hffff : sat_w[OUT_LEN_W-1:0];
        count_next   = sat;

        if (end_en)
        begin
            quote_next     = '0;
            phase_next     = PH_IDLE;
            acc_next       = '0;
            digits_next    = '0;
            held_next      = '0;
            held_flag_next = 1'b0;
            failed_next    = 1'b0;
            count_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quote_reg     <= '0;
            phase_reg     <= PH_IDLE;
            acc_reg       <= '0;
            digits_reg    <= '0;
            held_reg      <= '0;
            held_flag_reg <= 1'b0;
            failed_reg    <= 1'b0;
            count_reg     <= '0;
        end
        else if (fire)
        begin
            quote_reg     <= quote_next;
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            digits_reg    <= digits_next;
            held_reg      <= held_next;
            held_flag_reg <= held_flag_next;
            failed_reg    <= failed_next;
            count_reg     <= count_next;
        end
    end

    a_held_phase: assert property (@(posedge clk) disable iff (!rst_n)
        held_flag_reg |-> (phase_reg == PH_HELD || phase_reg == PH_HELD_ESC
                           || phase_reg == PH_HELD_U || phase_reg == PH_HELD_BAD))
        else $error("held surrogate outside a held phase");

    a_failed_phase: assert property (@(posedge clk) disable iff (!rst_n)
        failed_reg |-> (phase_reg == PH_FAILED && !held_flag_reg))
        else $error("failed token not parked");

    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && cur_last) |=> (phase_reg == PH_IDLE && count_reg == '0))
        else $error("end item did not reset token state");

endmodule

`default_nettype wire

/* src/qsu_out_stage.sv */
// ----------------------------------------------------------------------------
// qsu_out_stage: result register and drain
// Holds one batch and presents its results one item per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module qsu_out_stage
    import qsu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        fire,
    input  wire qsu_batch_t  batch,
    output logic             space,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic             out_is_end,
    output logic             out_error,
    output logic [15:0]      out_length,
    output logic             out_step_last
);

    logic [NUM_SLOTS-1:0][7:0] bytes_reg;
    logic [2:0]                rem_reg;
    logic [2:0]                rem_next;
    logic                      end_reg;
    logic                      err_reg;
    logic [OUT_LEN_W-1:0]      len_reg;
    logic                      take;

    assign out_valid     = rem_reg != 3'd0;
    assign take          = out_valid && out_ready;
    assign space         = (rem_reg == 3'd0) || (rem_reg == 3'd1 && out_ready);
    assign out_byte      = bytes_reg[0];
    assign out_step_last = rem_reg == 3'd1;
    assign out_is_end    = end_reg && out_step_last;
    assign out_error     = out_is_end && err_reg;
    assign out_length    = out_is_end ? len_reg : '0;

    always_comb
    begin
        rem_next = rem_reg;
        if (fire)
        begin
            rem_next = batch.count;
        end
        else if (take)
        begin
            rem_next = rem_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            bytes_reg <= batch.bytes;
            end_reg   <= batch.is_end;
            err_reg   <= batch.error;
            len_reg   <= batch.length;
        end
        else if (take)
        begin
            bytes_reg <= bytes_reg >> 8;
        end
    end

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= 3'(NUM_SLOTS))
        else $error("result count out of range");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> (rem_reg == 3'd0 || (rem_reg == 3'd1 && out_ready)))
        else $error("batch loaded over pending results");

endmodule

`default_nettype wire

/* src/quoted_string_unescaper.sv */
// An accepted item waits in the input register until the result register can take its
// results. Throughput: one item per cycle while each item gives at most one result and
// out_ready is high; an item giving more results holds the input while they drain.
// The decode logic sits between the input register and the result register.
// Reset: rst_n clears all token state; the block then awaits an opening quote.
// ----------------------------------------------------------------------------
// quoted_string_unescaper: top level
// Input register, escape decoder and result drain for quoted string tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module quoted_string_unescaper
    import qsu_pkg::*;
#(
    parameter int LEN_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    input  wire logic        in_last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic             out_is_end,
    output logic             out_error,
    output logic [15:0]      out_length,
    output logic             out_step_last
);

    logic       space;
    logic       fire;
    logic [7:0] cur_byte;
    logic       cur_last;
    qsu_batch_t batch;

    qsu_in_stage u_in
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .space    (space),
        .fire     (fire),
        .cur_byte (cur_byte),
        .cur_last (cur_last)
    );

    qsu_decoder #(.LEN_BITS(LEN_BITS)) u_dec
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .cur_byte (cur_byte),
        .cur_last (cur_last),
        .batch    (batch)
    );

    qsu_out_stage u_out
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .batch         (batch),
        .space         (space),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .out_is_end    (out_is_end),
        .out_error     (out_error),
        .out_length    (out_length),
        .out_step_last (out_step_last)
    );

endmodule

`default_nettype wire

/* tb/sv/tb_quoted_string_unescaper.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quoted_string_unescaper: self-checking bench for the string unescaper
// Feeds directed and random quoted tokens, byte by byte, under random
// back-pressure. A software decoder predicts every decoded byte and end item,
// and each result leaving the block is checked field by field in order.
// ----------------------------------------------------------------------------

module tb_quoted_string_unescaper;
    import qsu_pkg::*;

    localparam int          LEN_BITS       = 16;
    localparam int          CLK_PERIOD     = 10;
    localparam int          TIMEOUT_CYCLES = 1_000_000;
    localparam int          RANDOM_BYTES   = 90;
    localparam int          HOLD_CYCLES    = 120;
    localparam int          DRAIN_CYCLES   = 8;
    localparam int          REPORT_MAX     = 100;
    localparam logic [7:0]  CH_BSLASH      = 8'h5c;
    localparam logic [7:0]  CH_DQUOTE      = 8'h22;
    localparam logic [7:0]  CH_SQUOTE      = 8'h27;
    localparam logic [7:0]  CH_BQUOTE      = 8'h60;

    typedef enum logic [3:0] {
        PH_WAIT_QUOTE,
        PH_TEXT,
        PH_ESCAPE,
        PH_HEX_BYTE,
        PH_HEX_UNIT,
        PH_SURR_HELD,
        PH_SURR_ESCAPE,
        PH_SURR_UNIT,
        PH_SURR_SKIP,
        PH_DEAD
    } parse_phase_e;

    typedef enum logic [1:0] {
        RX_STREAM,
        RX_RANDOM,
        RX_PERIODIC
    } rx_mode_e;

    typedef struct packed {
        logic [7:0]  data;
        logic        is_end;
        logic        error;
        logic [15:0] length;
        logic        step_last;
    } decoded_t;

    class unescape_tracker;
        logic [7:0]          quote_char;
        parse_phase_e        phase;
        logic [15:0]         hex_acc;
        int unsigned         hex_count;
        logic [9:0]          held_bits;
        bit                  held;
        bit                  failed;
        logic [LEN_BITS-1:0] byte_count;
        decoded_t            step_q[$];
        decoded_t            pending_decoded[$];
        int unsigned         mismatches;

        function new();
            clear_token();
            mismatches = 0;
        endfunction

        function void clear_token();
            quote_char = '0;
            phase      = PH_WAIT_QUOTE;
            hex_acc    = '0;
            hex_count  = 0;
            held_bits  = '0;
            held       = 1'b0;
            failed     = 1'b0;
            byte_count = '0;
        endfunction

        function void put(logic [7:0] b, logic e, logic err, logic [15:0] len);
            step_q.push_back('{b, e, err, len, 1'b0});
        endfunction

        function void put_byte(logic [7:0] b);
            put(b, 1'b0, 1'b0, 16'h0);
            if (byte_count != '1)
                byte_count++;
        endfunction

        function void put_utf8(logic [20:0] v);
            if (v < 21'h80)
                put_byte(v[7:0]);
            else if (v < 21'h800)
            begin
                put_byte(8'hc0 | 8'(v >> 6));
                put_byte(8'h80 | 8'(v & 21'h3f));
            end
            else if (v < 21'h10000)
            begin
                put_byte(8'he0 | 8'(v >> 12));
                put_byte(8'h80 | 8'((v >> 6) & 21'h3f));
                put_byte(8'h80 | 8'(v & 21'h3f));
            end
            else
            begin
                put_byte(8'hf0 | 8'((v >> 18) & 21'h7));
                put_byte(8'h80 | 8'((v >> 12) & 21'h3f));
                put_byte(8'h80 | 8'((v >> 6) & 21'h3f));
                put_byte(8'h80 | 8'(v & 21'h3f));
            end
        endfunction

        function int hex_digit(logic [7:0] c);
            if (c >= "0" && c <= "9")
                return int'(c - "0");
            if (c >= "a" && c <= "f")
                return int'(c - "a") + 10;
            if (c >= "A" && c <= "F")
                return int'(c - "A") + 10;
            return -1;
        endfunction

        function void fail_token();
            failed = 1'b1;
            held   = 1'b0;
            phase  = PH_DEAD;
        endfunction

        function void flush_held();
            if (held)
                put_utf8(21'(16'hd800 | {6'b0, held_bits}));
            held      = 1'b0;
            held_bits = '0;
        endfunction

        function void finish_unit(logic [15:0] v);
            if (v >= 16'hd800 && v < 16'hdc00)
            begin
                held_bits = v[9:0];
                held      = 1'b1;
                phase     = PH_SURR_HELD;
            end
            else
            begin
                put_utf8(21'(v));
                phase = PH_TEXT;
            end
        endfunction

        function void escape(logic [7:0] c);
            logic [7:0] b;
            case (c)
                CH_BSLASH, CH_DQUOTE, CH_SQUOTE, CH_BQUOTE, "/": b = c;
                "0": b = 8'h00;
                "b": b = 8'h08;
                "t": b = 8'h09;
                "n": b = 8'h0a;
                "f": b = 8'h0c;
                "r": b = 8'h0d;
                "e": b = 8'h1b;
                "x", "u":
                begin
                    hex_acc   = '0;
                    hex_count = 0;
                    phase     = (c == "x") ? PH_HEX_BYTE : PH_HEX_UNIT;
                    return;
                end
                default:
                begin
                    fail_token();
                    return;
                end
            endcase
            put_byte(b);
            phase = PH_TEXT;
        endfunction

        function void note_token_byte(logic [7:0] c, logic last);
            int          d;
            int unsigned left;
            logic        err;
            logic [31:0] n;
            decoded_t    tail;
            step_q.delete();
            if (last)
            begin
                err = failed;
                if (!err)
                begin
                    if (phase == PH_WAIT_QUOTE || c != quote_char)
                        err = 1'b1;
                    else
                    begin
                        flush_held();
                        if (phase != PH_TEXT && phase != PH_SURR_HELD)
                            err = 1'b1;
                    end
                end
                n = 32'(byte_count);
                put(8'h00, 1'b1, err, (n > 32'hffff) ? 16'hffff : n[15:0]);
                clear_token();
            end
            else if (!failed)
            begin
                case (phase)
                    PH_WAIT_QUOTE:
                        if (c == CH_DQUOTE || c == CH_SQUOTE || c == CH_BQUOTE)
                        begin
                            quote_char = c;
                            phase      = PH_TEXT;
                        end
                        else
                            fail_token();
                    PH_TEXT:
                        if (c == CH_BSLASH)
                            phase = PH_ESCAPE;
                        else
                            put_byte(c);
                    PH_ESCAPE:
                        escape(c);
                    PH_HEX_BYTE, PH_HEX_UNIT:
                    begin
                        d = hex_digit(c);
                        if (d < 0)
                            fail_token();
                        else
                        begin
                            hex_acc = {hex_acc[11:0], 4'(d)};
                            hex_count++;
                            if (phase == PH_HEX_BYTE && hex_count >= 2)
                            begin
                                put_byte(hex_acc[7:0]);
                                phase = PH_TEXT;
                            end
                            else if (phase == PH_HEX_UNIT && hex_count >= 4)
                                finish_unit(hex_acc);
                        end
                    end
                    PH_SURR_HELD:
                        if (c == CH_BSLASH)
                            phase = PH_SURR_ESCAPE;
                        else
                        begin
                            flush_held();
                            put_byte(c);
                            phase = PH_TEXT;
                        end
                    PH_SURR_ESCAPE:
                        if (c == "u")
                        begin
                            hex_acc   = '0;
                            hex_count = 0;
                            phase     = PH_SURR_UNIT;
                        end
                        else
                        begin
                            flush_held();
                            escape(c);
                        end
                    PH_SURR_UNIT:
                    begin
                        d = hex_digit(c);
                        if (d < 0)
                        begin
                            left = 3 - (hex_count & 3);
                            if (left == 0)
                                fail_token();
                            else
                            begin
                                hex_count = left;
                                phase     = PH_SURR_SKIP;
                            end
                        end
                        else
                        begin
                            hex_acc = {hex_acc[11:0], 4'(d)};
                            hex_count++;
                            if (hex_count >= 4)
                            begin
                                if (hex_acc >= 16'hdc00 && hex_acc < 16'he000)
                                begin
                                    held      = 1'b0;
                                    put_utf8(21'h10000 + {held_bits, hex_acc[9:0]});
                                    held_bits = '0;
                                    phase     = PH_TEXT;
                                end
                                else
                                begin
                                    flush_held();
                                    finish_unit(hex_acc);
                                end
                            end
                        end
                    end
                    PH_SURR_SKIP:
                    begin
                        if (hex_count > 0)
                            hex_count--;
                        if (hex_count == 0)
                            fail_token();
                    end
                    default: ;
                endcase
            end
            if (step_q.size() > 0)
            begin
                tail           = step_q.pop_back();
                tail.step_last = 1'b1;
                step_q.push_back(tail);
                foreach (step_q[i])
                    pending_decoded.push_back(step_q[i]);
            end
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                if (mismatches < REPORT_MAX)
                    $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_decoded(logic [7:0] b, logic e, logic err,
                                    logic [15:0] len, logic sl);
            decoded_t want;
            if (pending_decoded.size() == 0)
            begin
                if (mismatches < REPORT_MAX)
                    $display("%0t: result expected none actual byte %0h end %0b length %0h",
                             $time, b, e, len);
                mismatches++;
                return;
            end
            want = pending_decoded.pop_front();
            compare_field("out_byte", 16'(want.data), 16'(b));
            compare_field("out_is_end", 16'(want.is_end), 16'(e));
            compare_field("out_error", 16'(want.error), 16'(err));
            compare_field("out_length", want.length, len);
            compare_field("out_step_last", 16'(want.step_last), 16'(sl));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [7:0]           in_byte;
    logic                 in_last;
    logic                 out_valid;
    logic                 out_ready;
    logic [7:0]           out_byte;
    logic                 out_is_end;
    logic                 out_error;
    logic [OUT_LEN_W-1:0] out_length;
    logic                 out_step_last;

    unescape_tracker tracker = new();
    logic [7:0]      tok[$];
    logic [7:0]      simple_esc [12] = '{CH_BSLASH, CH_DQUOTE, CH_SQUOTE, CH_BQUOTE,
                                         "/", "0", "b", "t", "n", "f", "r", "e"};
    rx_mode_e        rx_mode     = RX_STREAM;
    int              rx_hold     = 0;
    bit              gaps_on     = 1'b0;
    int              burst_left  = 0;
    int              random_bytes = 0;

    quoted_string_unescaper #(
        .LEN_BITS(LEN_BITS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .in_last      (in_last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .out_is_end   (out_is_end),
        .out_error    (out_error),
        .out_length   (out_length),
        .out_step_last(out_step_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("tb_quoted_string_unescaper failed");
        $finish;
    end

    initial
    begin
        int tick;
        tick      = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                out_ready <= 1'b0;
                rx_hold--;
            end
            else
            begin
                case (rx_mode)
                    RX_STREAM:   out_ready <= 1'b1;
                    RX_RANDOM:   out_ready <= ($urandom_range(0, 3) != 0);
                    RX_PERIODIC: out_ready <= (tick >= 3);
                    default:     out_ready <= 1'b1;
                endcase
                tick = (tick + 1) % 7;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_decoded(out_byte, out_is_end, out_error, out_length, out_step_last);
    end

    task automatic send_item(input logic [7:0] b, input logic l);
        int gap;
        if (gaps_on && burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.note_token_byte(b, l);
    endtask

    task automatic add_text(input string s);
        foreach (s[i])
            tok.push_back(s[i]);
    endtask

    task automatic send_token();
        foreach (tok[i])
            send_item(tok[i], i == tok.size() - 1);
        tok.delete();
    endtask

    task automatic send_text(input string s);
        add_text(s);
        send_token();
    endtask

    // drop valid before idling so the last item is not offered twice
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.pending_decoded.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 10)
            return "0" + 8'(n);
        return (($urandom_range(0, 1) != 0) ? "A" : "a") + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] pick_quote();
        case ($urandom_range(0, 2))
            0:       return CH_DQUOTE;
            1:       return CH_SQUOTE;
            default: return CH_BQUOTE;
        endcase
    endfunction

    task automatic add_unit(input logic [15:0] v);
        tok.push_back(CH_BSLASH);
        tok.push_back("u");
        for (int i = 3; i >= 0; i--)
            tok.push_back(hex_char(v[i*4 +: 4]));
    endtask

    task automatic build_random_token();
        logic [7:0] q;
        logic [7:0] c;
        int         n;
        int         keep;
        q = pick_quote();
        tok.push_back(q);
        n = $urandom_range(0, 8);
        repeat (n)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    do
                        c = 8'($urandom);
                    while (c == CH_BSLASH);
                    tok.push_back(c);
                end
                3:
                begin
                    tok.push_back(CH_BSLASH);
                    tok.push_back(simple_esc[$urandom_range(0, 11)]);
                end
                4:
                begin
                    tok.push_back(CH_BSLASH);
                    tok.push_back("x");
                    tok.push_back(hex_char(4'($urandom)));
                    tok.push_back(hex_char(4'($urandom)));
                end
                5:
                    add_unit(16'($urandom));
                6:
                    case ($urandom_range(0, 2))
                        0:       add_unit(16'($urandom_range(0, 16'h7f)));
                        1:       add_unit(16'($urandom_range(16'h80, 16'h7ff)));
                        default: add_unit(16'($urandom_range(16'h800, 16'hffff)));
                    endcase
                7:
                begin
                    add_unit(16'($urandom_range(16'hd800, 16'hdbff)));
                    add_unit(16'($urandom_range(16'hdc00, 16'hdfff)));
                end
                8:
                    add_unit(16'($urandom_range(16'hd800, 16'hdbff)));
                default:
                    add_unit(16'($urandom_range(16'hdc00, 16'hdfff)));
            endcase
        end
        tok.push_back(q);
        case ($urandom_range(0, 19))
            0, 1: tok[$urandom_range(0, tok.size() - 1)] = 8'($urandom);
            2:    tok[tok.size() - 1] = pick_quote();
            3:
            begin
                keep = $urandom_range(1, tok.size() - 1);
                while (tok.size() > keep)
                    void'(tok.pop_back());
            end
            4:    tok[0] = 8'($urandom);
            default: ;
        endcase
    endtask

    initial
    begin
        int tok_idx;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_byte  = '0;
        in_last  = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        rx_mode = RX_PERIODIC;
        gaps_on = 1'b1;
        send_text("\"");
        send_text("\"\"");
        add_text("\"a\"b'c");
        tok.push_back(CH_BQUOTE);
        send_text("d\"");
        add_text("'\\0\\b\\t\\n\\f\\r\\e\\\\\\\"\\'\\/\\");
        tok.push_back(CH_BQUOTE);
        send_text("'");
        tok.push_back(CH_BQUOTE);
        add_text("\\x00\\xff\\xAb\\x7F");
        tok.push_back(CH_BQUOTE);
        send_token();
        send_text("\"\\u0041\\u00e9\\u07FF\\u0800\\uFFFF\\u0000\"");
        send_text("\"\\ud83d\\ude00\\uDBFF\\uDFFF\\uD800\\uDC00\"");
        send_text("\"\\ud800x\\ud801\\n\\ud802\\u0041\\ud803\\udbff\"");
        send_text("'\\ud800\\u12z456'");
        send_text("'\\ud800\\u1z'");
        send_text("'\\ud800\\u123z'");
        send_text("ab\"");
        send_text("\"abc'");
        send_text("\"\\ud800'");
        send_text("\"\\\"");
        send_text("\"\\ud800\\\"");
        send_text("\"\\x4\"");
        send_text("\"\\q\"");
        send_text("\"ab\\xg1cd\"");
        send_text("\"\\u12z4\"");
        tok.push_back(CH_DQUOTE);
        tok.push_back(8'h00);
        tok.push_back(8'hff);
        tok.push_back(8'h80);
        tok.push_back(8'hff);
        send_token();
        send_item(8'h00, 1'b1);

        tok_idx = 0;
        while (random_bytes < RANDOM_BYTES || tok_idx < 4)
        begin
            if (tok_idx % 2 == 0)
            begin
                rx_mode = rx_mode_e'($urandom_range(0, 2));
                gaps_on = ($urandom_range(0, 3) != 0);
            end
            // keep offering items while the output is held off
            if (tok_idx == 1)
            begin
                gaps_on = 1'b0;
                rx_hold = HOLD_CYCLES;
            end
            if (tok_idx == 3)
                wait_drained();
            build_random_token();
            random_bytes += tok.size();
            send_token();
            tok_idx++;
        end

        @(negedge clk);
        in_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending_decoded.size() == 0)
            $display("tb_quoted_string_unescaper passed");
        else
            $display("tb_quoted_string_unescaper failed");
        $finish;
    end

endmodule
